// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file btvl_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define BTVL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("btvl assertion failed");

// Checks that one condition is followed by another in the next cycle.
`define BTVL_ASSERT_NEXT(lbl, cond, nxt) \
  `BTVL_ASSERT(lbl, (cond) |=> (nxt))

`endif

// ===== rtl/core/btvl_pkg.sv =====
package btvl_pkg;

  localparam int COORD_W  = 10;
  localparam int BRICK_W  = 8;
  localparam int INDEX_W  = 6;
  localparam int DIGIT_W  = 2;
  localparam int CELL_W   = 3 * DIGIT_W;
  localparam int LEVEL_W  = 3;
  localparam int VALUE_W  = 8;
  localparam int SRC_W    = 2;
  localparam int OP_W     = 3;
  localparam int MAP_W    = INDEX_W + 1;
  localparam int LINK_W   = BRICK_W + 1;
  localparam int NUM_BRICKS       = 1 << BRICK_W;
  localparam int NUM_INDEX_BRICKS = 1 << INDEX_W;
  localparam int CELLS            = 1 << CELL_W;
  localparam int MAX_LEVELS       = 5;
  // Coordinates are widened so the parent digit of the top level reads as zero.
  localparam int CEXT_W = 2 * DIGIT_W * (MAX_LEVELS + 1) / 2 + DIGIT_W;

  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
  localparam logic [OP_W-1:0] OP_MAP    = 3'd1;
  localparam logic [OP_W-1:0] OP_LINK   = 3'd2;
  localparam logic [OP_W-1:0] OP_VOXEL  = 3'd3;
  localparam logic [OP_W-1:0] OP_LOADED = 3'd4;

  localparam logic [SRC_W-1:0] SRC_CURRENT = 2'd0;
  localparam logic [SRC_W-1:0] SRC_PARENT  = 2'd1;
  localparam logic [SRC_W-1:0] SRC_AVERAGE = 2'd2;

  localparam logic [1:0] REG_LEVELS  = 2'd0;
  localparam logic [1:0] REG_STREAM  = 2'd1;
  localparam logic [1:0] REG_AVERAGE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LEVEL, ST_MAP, ST_LINK, ST_VOXEL, ST_VWAIT, ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic descend;
    logic pick_vox;
    logic take_vox;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic at_leaf;
    logic map_hit;
    logic link_hit;
    logic out_free;
  } status_t;

  function automatic logic [CELL_W-1:0] cell_at(
    input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
    input logic [COORD_W-1:0] cz, input logic [LEVEL_W:0] sh);
    logic [CEXT_W-1:0] ex, ey, ez;
    ex = CEXT_W'(cx) >> (DIGIT_W * sh);
    ey = CEXT_W'(cy) >> (DIGIT_W * sh);
    ez = CEXT_W'(cz) >> (DIGIT_W * sh);
    return {ez[DIGIT_W-1:0], ey[DIGIT_W-1:0], ex[DIGIT_W-1:0]};
  endfunction

endpackage

// ===== rtl/core/btvl_ram.sv =====
module btvl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/btvl_ctrl.sv =====
module btvl_ctrl import btvl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = status_i.is_lookup ? ST_LEVEL : ST_DONE;
        end
      end
      ST_LEVEL: begin
        state_d = status_i.at_leaf ? ST_VOXEL : ST_MAP;
      end
      ST_MAP: begin
        state_d = status_i.map_hit ? ST_LINK : ST_VOXEL;
      end
      ST_LINK: begin
        if (status_i.link_hit) begin
          cmd_o.descend = 1'b1;
          state_d = ST_LEVEL;
        end else begin
          state_d = ST_VOXEL;
        end
      end
      ST_VOXEL: begin
        cmd_o.pick_vox = 1'b1;
        state_d = ST_VWAIT;
      end
      ST_VWAIT: begin
        cmd_o.take_vox = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/btvl_dp.sv =====
module btvl_dp import btvl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic [LEVEL_W-1:0]  levels_i,
  input  logic                stream_i,
  input  logic [VALUE_W-1:0]  average_i,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [COORD_W-1:0]  coord_x_i,
  input  logic [COORD_W-1:0]  coord_y_i,
  input  logic [COORD_W-1:0]  coord_z_i,
  input  logic [BRICK_W-1:0]  brick_number_i,
  input  logic [INDEX_W-1:0]  index_number_i,
  input  logic [CELL_W-1:0]   cell_req_i,
  input  logic                link_valid_i,
  input  logic [BRICK_W-1:0]  child_number_i,
  input  logic [VALUE_W-1:0]  voxel_value_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [VALUE_W-1:0]  result_value_o,
  output logic [SRC_W-1:0]    source_o,
  output logic [BRICK_W-1:0]  final_brick_o,
  output logic                newly_requested_o
);

  logic [COORD_W-1:0] cx_q, cy_q, cz_q;
  logic [LEVEL_W-1:0] level_q;
  logic [BRICK_W-1:0] brick_q, parent_q;
  logic               has_parent_q;
  logic [SRC_W-1:0]   src_q;
  logic               newreq_q;
  logic [VALUE_W-1:0] val_q;
  logic [NUM_BRICKS-1:0] loaded_q, requested_q;

  logic               out_valid_q;
  logic [VALUE_W-1:0] out_val_q;
  logic [SRC_W-1:0]   out_src_q;
  logic [BRICK_W-1:0] out_brick_q;
  logic               out_newreq_q;

  logic [CELL_W-1:0]  ccell, pcell;
  logic [MAP_W-1:0]   map_rdata;
  logic [LINK_W-1:0]  link_rdata;
  logic [VALUE_W-1:0] vox_rdata;
  logic [SRC_W-1:0]   sel_src;
  logic               sel_newreq;
  logic [BRICK_W+CELL_W-1:0] vox_raddr;

  // The child cell uses the digit just below the current level, the parent cell
  // the digit of the current level itself.
  assign ccell = cell_at(cx_q, cy_q, cz_q, {1'b0, level_q - LEVEL_W'(1)});
  assign pcell = cell_at(cx_q, cy_q, cz_q, {1'b0, level_q});

  btvl_ram #(.WIDTH(MAP_W), .DEPTH(NUM_BRICKS)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && operation_i == OP_MAP),
    .waddr_i (brick_number_i),
    .wdata_i ({link_valid_i, link_valid_i ? index_number_i : INDEX_W'(0)}),
    .raddr_i (brick_q),
    .rdata_o (map_rdata)
  );

  btvl_ram #(.WIDTH(LINK_W), .DEPTH(NUM_INDEX_BRICKS * CELLS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && operation_i == OP_LINK),
    .waddr_i ({index_number_i, cell_req_i}),
    .wdata_i ({link_valid_i, link_valid_i ? child_number_i : BRICK_W'(0)}),
    .raddr_i ({map_rdata[INDEX_W-1:0], ccell}),
    .rdata_o (link_rdata)
  );

  btvl_ram #(.WIDTH(VALUE_W), .DEPTH(NUM_BRICKS * CELLS)) u_vox_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && operation_i == OP_VOXEL),
    .waddr_i ({brick_number_i, cell_req_i}),
    .wdata_i (voxel_value_i),
    .raddr_i (vox_raddr),
    .rdata_o (vox_rdata)
  );

  always_comb begin
    sel_src    = SRC_CURRENT;
    sel_newreq = 1'b0;
    if (stream_i && !loaded_q[brick_q]) begin
      if (requested_q[brick_q]) begin
        sel_src = (has_parent_q && loaded_q[parent_q]) ? SRC_PARENT : SRC_AVERAGE;
      end else begin
        sel_src    = SRC_AVERAGE;
        sel_newreq = 1'b1;
      end
    end
    vox_raddr = (sel_src == SRC_PARENT) ? {parent_q, pcell} : {brick_q, ccell};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cx_q         <= coord_x_i;
      cy_q         <= coord_y_i;
      cz_q         <= coord_z_i;
      level_q      <= levels_i;
      brick_q      <= '0;
      parent_q     <= '0;
      has_parent_q <= 1'b0;
      src_q        <= SRC_CURRENT;
      newreq_q     <= 1'b0;
      val_q        <= '0;
    end
    if (cmd_i.descend) begin
      parent_q     <= brick_q;
      has_parent_q <= 1'b1;
      brick_q      <= link_rdata[BRICK_W-1:0];
      level_q      <= level_q - LEVEL_W'(1);
    end
    if (cmd_i.pick_vox) begin
      src_q    <= sel_src;
      newreq_q <= sel_newreq;
    end
    if (cmd_i.take_vox) begin
      val_q <= (src_q == SRC_AVERAGE) ? average_i : vox_rdata;
    end
    if (cmd_i.finish) begin
      out_val_q    <= val_q;
      out_src_q    <= src_q;
      out_brick_q  <= brick_q;
      out_newreq_q <= newreq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      requested_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && operation_i == OP_LOADED) begin
        loaded_q[brick_number_i] <= 1'b1;
      end
      if (cmd_i.pick_vox && sel_newreq) begin
        requested_q[brick_q] <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.is_lookup = (operation_i == OP_LOOKUP);
  assign status_o.at_leaf   = (level_q == LEVEL_W'(1));
  assign status_o.map_hit   = map_rdata[MAP_W-1];
  assign status_o.link_hit  = link_rdata[LINK_W-1];
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign result_value_o    = out_val_q;
  assign source_o          = out_src_q;
  assign final_brick_o     = out_brick_q;
  assign newly_requested_o = out_newreq_q;

endmodule

// ===== rtl/core/brick_tree_voxel_lookup.sv =====
// Channel     | Handshake           | Payload
// ------------+---------------------+---------------------------------------------
// request in  | in_valid_i/in_stall_o | operation, coords, ids, cell, link, voxel
// result out  | out_valid_o/out_stall_i | result_value, source, final_brick, flag
// config      | APB psel/penable      | tree_levels, stream_mode, average_value
//
// A write request goes from acceptance straight to the final state, which
// issues its result. A lookup walks the tree level by level, descending at most
// tree_levels - 1 levels; each level costs a map RAM read and a child link RAM
// read. The walk stops at the leaf level, on a missing map entry or on a missing
// child link, and a final voxel RAM read then gives the result. The controller
// returns to idle before it takes the next request. One request is in work at a
// time. Reset clears the state machine, the output valid and the loaded and
// requested flags; the map, link and voxel RAMs are not cleared and hold nothing
// defined until written. A new request is taken while the previous result still
// waits on a stalled output; it then waits in its final state until the output
// frees.
module brick_tree_voxel_lookup import btvl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [COORD_W-1:0]  coord_x_i,
  input  logic [COORD_W-1:0]  coord_y_i,
  input  logic [COORD_W-1:0]  coord_z_i,
  input  logic [BRICK_W-1:0]  brick_number_i,
  input  logic [INDEX_W-1:0]  index_number_i,
  input  logic [CELL_W-1:0]   cell_req_i,
  input  logic                link_valid_i,
  input  logic [BRICK_W-1:0]  child_number_i,
  input  logic [VALUE_W-1:0]  voxel_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [VALUE_W-1:0]  result_value_o,
  output logic [SRC_W-1:0]    source_o,
  output logic [BRICK_W-1:0]  final_brick_o,
  output logic                newly_requested_o
);

  logic [LEVEL_W-1:0] levels_q;
  logic               stream_q;
  logic [VALUE_W-1:0] average_q;
  logic [LEVEL_W-1:0] levels_eff;
  logic               cfg_write;
  cmd_t               cmd;
  status_t            status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // Configuration registers sit at word addresses; a write beyond them is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q  <= LEVEL_W'(MAX_LEVELS);
      stream_q  <= 1'b0;
      average_q <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_LEVELS:  levels_q  <= pwdata[LEVEL_W-1:0];
        REG_STREAM:  stream_q  <= pwdata[0];
        REG_AVERAGE: average_q <= pwdata[VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LEVELS:  prdata = 32'(levels_q);
      REG_STREAM:  prdata = 32'(stream_q);
      REG_AVERAGE: prdata = 32'(average_q);
      default:     prdata = '0;
    endcase
  end

  // Out-of-range tree depths are clamped into the supported range.
  always_comb begin
    if (levels_q == '0) begin
      levels_eff = LEVEL_W'(1);
    end else if (levels_q > LEVEL_W'(MAX_LEVELS)) begin
      levels_eff = LEVEL_W'(MAX_LEVELS);
    end else begin
      levels_eff = levels_q;
    end
  end

  btvl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  btvl_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .levels_i          (levels_eff),
    .stream_i          (stream_q),
    .average_i         (average_q),
    .operation_i       (operation_i),
    .coord_x_i         (coord_x_i),
    .coord_y_i         (coord_y_i),
    .coord_z_i         (coord_z_i),
    .brick_number_i    (brick_number_i),
    .index_number_i    (index_number_i),
    .cell_req_i        (cell_req_i),
    .link_valid_i      (link_valid_i),
    .child_number_i    (child_number_i),
    .voxel_value_i     (voxel_value_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .result_value_o    (result_value_o),
    .source_o          (source_o),
    .final_brick_o     (final_brick_o),
    .newly_requested_o (newly_requested_o)
  );

endmodule

// ===== rtl/core/btvl_chk.sv =====
`include "assert_macros.svh"

module btvl_chk import btvl_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  result_value_o,
  input logic [1:0]  source_o,
  input logic [7:0]  final_brick_o,
  input logic        newly_requested_o
);

  logic [VALUE_W+SRC_W+BRICK_W:0] out_payload;

  assign out_payload = {result_value_o, source_o, final_brick_o, newly_requested_o};

  // A stalled result keeps its contents.
  `BTVL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_payload))
  // A freshly requested brick is always answered with the average value.
  `BTVL_ASSERT(a_newreq_avg, (out_valid_o && newly_requested_o) |-> (source_o == SRC_AVERAGE))
  // The source code never takes its unused value.
  `BTVL_ASSERT(a_src_legal, out_valid_o |-> (source_o <= SRC_AVERAGE))
  // Right after a request is taken the block is busy with it.
  `BTVL_ASSERT_NEXT(a_busy_after, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind brick_tree_voxel_lookup btvl_chk u_btvl_chk (.*);
